FILE: hdl/api_pkg.sv
package api_pkg;

  // coordinate format and iteration counts
  localparam int unsigned CoordW     = 32;
  localparam int unsigned ScaleShift = 58 - CoordW;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned MaxSegments = 63;
  localparam logic [31:0] GainK32    = 32'd2608131496;

  // fixed angles in units of 2^-32 turn
  localparam logic [31:0] AngQuarter      = 32'h4000_0000;
  localparam logic [31:0] AngHalf         = 32'h8000_0000;
  localparam logic [31:0] AngThreeQuarter = 32'hC000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_LUT [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // cordic unit command
  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_VB,
    S_VB_W,
    S_MR_W,
    S_VF,
    S_VF_W,
    S_MX,
    S_MX_W,
    S_DIV,
    S_DIV_W,
    S_ROT,
    S_ROT_W,
    S_OUT
  } state_e;

endpackage

FILE: hdl/api_cordic.sv
module api_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  api_pkg::cordic_cmd_t cmd_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [33:0] z_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [33:0] z_o,
  output logic               done_o
);
  import api_pkg::*;

  logic signed [63:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d, rot_q, rot_d;
  logic signed [63:0] xs, ys;
  logic signed [33:0] at;
  logic neg;

  // one micro-rotation per cycle
  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = {2'b00, ATAN_LUT[i_q]};
    neg = rot_q ? !z_q[33] : y_q[63];
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; done_d = 1'b0; rot_d = rot_q;
    if (cmd_i.start) begin
      x_d = x_i; y_d = y_i; z_d = z_i; i_d = '0;
      busy_d = 1'b1; rot_d = cmd_i.rotate;
    end else if (busy_q) begin
      if (neg) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      rot_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
      rot_q  <= rot_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign done_o = done_q;
endmodule

FILE: hdl/api_mul.sv
module api_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  output logic [63:0] p_o,
  output logic        done_o
);
  import api_pkg::*;

  logic [63:0] a_q;
  logic [64:0] acc_q, acc_d, sum;
  logic [4:0] b_q, b_d;
  logic busy_q, busy_d, done_q, done_d;

  // one gain bit per cycle, lsb first, shifting out the low bits
  always_comb begin
    sum = acc_q + (GainK32[b_q] ? {1'b0, a_q} : 65'd0);
    acc_d = acc_q; b_d = b_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; b_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = sum >> 1;
      b_d = b_q + 5'd1;
      if (b_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      b_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      b_q    <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) a_q <= a_i;
  end

  assign p_o = acc_q[63:0];
  assign done_o = done_q;
endmodule

FILE: hdl/api_div.sv
module api_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [37:0] num_i,
  input  logic [5:0]  den_i,
  output logic [37:0] quo_o,
  output logic        done_o
);
  logic [37:0] q_q, q_d;
  logic [5:0] rem_q, rem_d, den_q;
  logic [6:0] rem_sh;
  logic [5:0] c_q, c_d;
  logic busy_q, busy_d, done_q, done_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, q_q[37]};
    q_d = q_q; rem_d = rem_q; c_d = c_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      q_d = num_i; rem_d = '0; c_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = 6'(rem_sh - {1'b0, den_q});
        q_d = {q_q[36:0], 1'b1};
      end else begin
        rem_d = rem_sh[5:0];
        q_d = {q_q[36:0], 1'b0};
      end
      c_d = c_q + 6'd1;
      if (c_q == 6'd37) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      c_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      c_q    <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign quo_o = q_q;
  assign done_o = done_q;
endmodule

FILE: hdl/arc_point_interpolator.sv
// arc point interpolator
// slave stream takes one arc per word: tdata holds center, start and end
// points (signed q16.16) and the segment count n, tuser the direction
// (1 clockwise). the master stream returns n+1 points on the circle, each
// with its index, tlast set on the point at the end angle.
// start and end angles come from a shared iterative cordic (24 iterations),
// the radius and the rotation start value from a serial gain multiply
// (32 gain bits). each point takes a serial divide (38 quotient bits) for
// its angle offset, a cordic rotation and an output step; setup is shorter
// when a point lies on the vertical through the center, as its cordic
// vectoring is then skipped.
// one arc is in work at a time: s_axis_tready_o is high only while idle.
// points sit in an output register; while the receiver stalls the next
// point is computed and then held until the register frees up. the final
// point may wait there while the next arc is already accepted.
// reset clears the sequencer and the output valid; no arc is in flight.
module arc_point_interpolator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // center_x, center_y, begin_x, begin_y, finish_x, finish_y, segments, pad
  input  logic [199:0] s_axis_tdata_i,
  // clockwise
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // point_x, point_y, point_index, pad
  output logic [71:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o
);
  import api_pkg::*;

  state_e state_q, state_d;

  logic signed [31:0] cx_q, cy_q;
  logic signed [32:0] dxb_q, dyb_q, dxf_q, dyf_q;
  logic cw_q, flip_q;
  logic [5:0] n_q, k_q;
  logic [31:0] as_q, ae_q, rad_q, sweep_q, ang_q;
  logic [63:0] x0_q;
  logic [37:0] num_q;
  logic signed [31:0] px_q, py_q;

  logic m_valid_q, m_last_q;
  logic [31:0] mx_q, my_q;
  logic [5:0] mk_q;

  cordic_cmd_t cor_cmd;
  logic signed [63:0] cor_xi, cor_yi, cor_xo, cor_yo;
  logic signed [33:0] cor_zi, cor_zo;
  logic cor_done;
  logic mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_p;
  logic [37:0] div_q;

  logic accept, out_free;
  logic signed [32:0] vdx, vdy;
  logic signed [63:0] vx, vy;
  logic [5:0] seg_in, seg_cl;
  logic [31:0] off, ang_raw, ang_tst;
  logic [37:0] rad_r;
  logic signed [63:0] rx, ry, rxr, ryr;
  logic signed [39:0] sx, sy;
  logic [31:0] vz_b, vz_f;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // segment count clamp
  always_comb begin
    seg_in = s_axis_tdata_i[197:192];
    seg_cl = seg_in;
    if (seg_in == 6'd0) seg_cl = 6'd1;
    if (seg_in > 6'(MaxSegments)) seg_cl = 6'(MaxSegments);
  end

  // vectoring start vector, mirrored into the right half plane; rotation input in S_ROT
  always_comb begin
    vdx = (state_q == S_VF) ? dxf_q : dxb_q;
    vdy = (state_q == S_VF) ? dyf_q : dyb_q;
    vx = {{5{vdx[32]}}, vdx, 26'd0};
    vy = {{5{vdy[32]}}, vdy, 26'd0};
    cor_zi = '0;
    if (vdx[32]) begin
      vx = -vx;
      vy = -vy;
      cor_zi = {2'b00, AngHalf};
    end
    cor_xi = vx;
    cor_yi = vy;
    if (state_q == S_ROT) begin
      cor_xi = signed'(x0_q);
      cor_yi = '0;
      cor_zi = {{2{ang_q[31]}}, ang_q};
    end
  end

  // special angles for a point on the vertical through the center
  assign vz_b = (!dyb_q[32] && dyb_q != 33'sd0) ? AngQuarter : AngThreeQuarter;
  assign vz_f = (!dyf_q[32] && dyf_q != 33'sd0) ? AngQuarter : AngThreeQuarter;

  // angle of the next point, folded into the right half plane
  always_comb begin
    off = div_q[31:0];
    ang_raw = cw_q ? as_q - off : as_q + off;
    ang_tst = ang_raw + AngQuarter;
  end

  // rounded radius from the gain product
  assign rad_r = 38'((mul_p + (64'd1 << (ScaleShift - 1))) >> ScaleShift);

  // rotated point, rounded and added to the center
  always_comb begin
    rx = flip_q ? -cor_xo : cor_xo;
    ry = flip_q ? -cor_yo : cor_yo;
    rxr = (rx + (64'sd1 <<< (ScaleShift - 1))) >>> ScaleShift;
    ryr = (ry + (64'sd1 <<< (ScaleShift - 1))) >>> ScaleShift;
    sx = 40'(signed'(cx_q)) + rxr[39:0];
    sy = 40'(signed'(cy_q)) + ryr[39:0];
  end

  assign mul_a = (state_q == S_VB_W) ? cor_xo : {6'd0, rad_q, 26'd0};

  // sequencer
  always_comb begin
    state_d = state_q;
    cor_cmd = '{start: 1'b0, rotate: 1'b0};
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_VB;
      S_VB: begin
        if (dxb_q == 33'sd0) state_d = S_VF;
        else begin
          cor_cmd.start = 1'b1;
          state_d = S_VB_W;
        end
      end
      S_VB_W: begin
        if (cor_done) begin
          mul_start = 1'b1;
          state_d = S_MR_W;
        end
      end
      S_MR_W:  if (mul_done) state_d = S_VF;
      S_VF: begin
        if (dxf_q == 33'sd0) state_d = S_MX;
        else begin
          cor_cmd.start = 1'b1;
          state_d = S_VF_W;
        end
      end
      S_VF_W:  if (cor_done) state_d = S_MX;
      S_MX: begin
        mul_start = 1'b1;
        state_d = S_MX_W;
      end
      S_MX_W:  if (mul_done) state_d = S_DIV;
      S_DIV: begin
        div_start = 1'b1;
        state_d = S_DIV_W;
      end
      S_DIV_W: if (div_done) state_d = S_ROT;
      S_ROT: begin
        cor_cmd = '{start: 1'b1, rotate: 1'b1};
        state_d = S_ROT_W;
      end
      S_ROT_W: if (cor_done) state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = (k_q == n_q) ? S_IDLE : S_DIV;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  // arc and point datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q  <= s_axis_tdata_i[31:0];
      cy_q  <= s_axis_tdata_i[63:32];
      dxb_q <= 33'(signed'(s_axis_tdata_i[95:64])) - 33'(signed'(s_axis_tdata_i[31:0]));
      dyb_q <= 33'(signed'(s_axis_tdata_i[127:96])) - 33'(signed'(s_axis_tdata_i[63:32]));
      dxf_q <= 33'(signed'(s_axis_tdata_i[159:128])) - 33'(signed'(s_axis_tdata_i[31:0]));
      dyf_q <= 33'(signed'(s_axis_tdata_i[191:160])) - 33'(signed'(s_axis_tdata_i[63:32]));
      n_q   <= seg_cl;
      cw_q  <= s_axis_tuser_i[0];
    end
    if (state_q == S_VB && dxb_q == 33'sd0) begin
      as_q  <= vz_b;
      rad_q <= dyb_q[32] ? 32'(-dyb_q) : dyb_q[31:0];
    end
    if (state_q == S_VB_W && cor_done) as_q <= cor_zo[31:0];
    if (state_q == S_MR_W && mul_done) begin
      rad_q <= (rad_r[37:32] != 6'd0) ? 32'hFFFF_FFFF : rad_r[31:0];
    end
    if (state_q == S_VF && dxf_q == 33'sd0) ae_q <= vz_f;
    if (state_q == S_VF_W && cor_done) ae_q <= cor_zo[31:0];
    if (state_q == S_MX_W && mul_done) begin
      x0_q    <= mul_p;
      sweep_q <= cw_q ? as_q - ae_q : ae_q - as_q;
      num_q   <= '0;
      k_q     <= '0;
    end
    if (state_q == S_DIV_W && div_done) begin
      flip_q <= ang_tst[31];
      ang_q  <= ang_tst[31] ? ang_raw ^ AngHalf : ang_raw;
    end
    if (state_q == S_ROT_W && cor_done) begin
      if (sx > 40'sd2147483647) px_q <= 32'h7FFF_FFFF;
      else if (sx < -40'sd2147483648) px_q <= 32'h8000_0000;
      else px_q <= sx[31:0];
      if (sy > 40'sd2147483647) py_q <= 32'h7FFF_FFFF;
      else if (sy < -40'sd2147483648) py_q <= 32'h8000_0000;
      else py_q <= sy[31:0];
    end
    if (state_q == S_OUT && out_free) begin
      mx_q     <= px_q;
      my_q     <= py_q;
      mk_q     <= k_q;
      m_last_q <= (k_q == n_q);
      k_q      <= k_q + 6'd1;
      num_q    <= num_q + {6'd0, sweep_q};
    end
  end

  api_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .x_i    (cor_xi),
    .y_i    (cor_yi),
    .z_i    (cor_zi),
    .x_o    (cor_xo),
    .y_o    (cor_yo),
    .z_o    (cor_zo),
    .done_o (cor_done)
  );

  api_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .p_o     (mul_p),
    .done_o  (mul_done)
  );

  api_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (n_q),
    .quo_o   (div_q),
    .done_o  (div_done)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, mk_q, my_q, mx_q};
  assign m_axis_tlast_o  = m_last_q;
endmodule
